>>> hw/rtl/mi3_pkg.sv
package mi3_pkg;

    localparam int DATA_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF  = 16;
    localparam int THR_W          = 31;
    localparam logic [THR_W-1:0] THR_RESET = 31'd1;
    localparam int NELEM          = 9;
    localparam int NROW           = 3;

    // operand indexes of each 2x2 cofactor: c = m[i0]*m[i1] - m[i2]*m[i3]
    localparam int COF_IDX [NELEM][4] = '{
        '{4, 8, 5, 7}, '{2, 7, 1, 8}, '{1, 5, 2, 4},
        '{5, 6, 3, 8}, '{0, 8, 2, 6}, '{2, 3, 0, 5},
        '{3, 7, 4, 6}, '{1, 6, 0, 7}, '{0, 4, 1, 3}
    };

    typedef struct packed {
        logic adv;
        logic vld;
    } pipe_ctl_t;

    typedef enum logic {
        STATUS_OK       = 1'b0,
        STATUS_SINGULAR = 1'b1
    } status_t;

endpackage

>>> hw/rtl/mi3_cfg_if.sv
interface mi3_cfg_if;
    logic                     valid;
    logic                     ready;
    logic [mi3_pkg::THR_W-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> hw/rtl/mi3_mat_if.sv
interface mi3_mat_if #(parameter int DW = mi3_pkg::DATA_WIDTH_DEF);
    logic                 valid;
    logic                 ready;
    logic signed [DW-1:0] a00, a01, a02, a10, a11, a12, a20, a21, a22;

    modport source (output valid, output a00, a01, a02, a10, a11, a12, a20, a21, a22,
                    input ready);
    modport sink   (input valid, input a00, a01, a02, a10, a11, a12, a20, a21, a22,
                    output ready);
endinterface

>>> hw/rtl/mi3_res_if.sv
interface mi3_res_if #(parameter int DW = mi3_pkg::DATA_WIDTH_DEF);
    logic                 valid;
    logic                 ready;
    logic signed [DW-1:0] b00, b01, b02, b10, b11, b12, b20, b21, b22;
    logic signed [DW-1:0] determinant;
    mi3_pkg::status_t     status;

    modport source (output valid, output b00, b01, b02, b10, b11, b12, b20, b21, b22,
                    output determinant, output status, input ready);
    modport sink   (input valid, input b00, b01, b02, b10, b11, b12, b20, b21, b22,
                    input determinant, input status, output ready);
endinterface

>>> hw/rtl/mi3_cof.sv
module mi3_cof #(
    parameter int W = mi3_pkg::DATA_WIDTH_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  mi3_pkg::pipe_ctl_t  ctl,
    input  logic signed [W-1:0] a    [mi3_pkg::NELEM],
    output logic signed [2*W:0] cof  [mi3_pkg::NELEM],
    output logic signed [W-1:0] row0 [mi3_pkg::NROW],
    output logic                vld
);
    import mi3_pkg::*;

    logic signed [2*W-1:0] pa_reg  [NELEM];
    logic signed [2*W-1:0] pb_reg  [NELEM];
    logic signed [2*W:0]   cof_reg [NELEM];
    logic signed [W-1:0]   ra_reg  [NROW];
    logic signed [W-1:0]   rb_reg  [NROW];
    logic                  va_reg;
    logic                  vb_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
        end
        else if (ctl.adv)
        begin
            va_reg <= ctl.vld;
            vb_reg <= va_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.adv)
        begin
            for (int k = 0; k < NELEM; k++)
            begin
                pa_reg[k]  <= a[COF_IDX[k][0]] * a[COF_IDX[k][1]];
                pb_reg[k]  <= a[COF_IDX[k][2]] * a[COF_IDX[k][3]];
                cof_reg[k] <= {pa_reg[k][2*W-1], pa_reg[k]} - {pb_reg[k][2*W-1], pb_reg[k]};
            end
            for (int j = 0; j < NROW; j++)
            begin
                ra_reg[j] <= a[j];
                rb_reg[j] <= ra_reg[j];
            end
        end
    end

    assign cof  = cof_reg;
    assign row0 = rb_reg;
    assign vld  = vb_reg;

endmodule

>>> hw/rtl/mi3_det.sv
module mi3_det #(
    parameter int W = mi3_pkg::DATA_WIDTH_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  mi3_pkg::pipe_ctl_t    ctl,
    input  logic signed [2*W:0]   cof     [mi3_pkg::NELEM],
    input  logic signed [W-1:0]   row0    [mi3_pkg::NROW],
    output logic signed [3*W+2:0] det,
    output logic signed [2*W:0]   cof_out [mi3_pkg::NELEM],
    output logic                  vld
);
    import mi3_pkg::*;

    localparam int NST = 3;

    logic signed [2*W:0]   ph_reg [NROW];
    logic signed [2*W:0]   pl_reg [NROW];
    logic signed [3*W:0]   t_reg  [NROW];
    logic signed [3*W+2:0] det_reg;
    logic signed [2*W:0]   cd_reg [NST][NELEM];
    logic [NST-1:0]        v_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else if (ctl.adv)
            v_reg <= {v_reg[NST-2:0], ctl.vld};
    end

    // split the wide cofactor into a signed high half and an unsigned low half
    always_ff @(posedge clk)
    begin
        if (ctl.adv)
        begin
            for (int j = 0; j < NROW; j++)
            begin
                ph_reg[j] <= row0[j] * $signed(cof[3*j][2*W:W]);
                pl_reg[j] <= row0[j] * $signed({1'b0, cof[3*j][W-1:0]});
                t_reg[j]  <= $signed({ph_reg[j], {W{1'b0}}}) + pl_reg[j];
            end
            det_reg <= t_reg[0] + t_reg[1] + t_reg[2];
            cd_reg[0] <= cof;
            for (int s = 1; s < NST; s++)
                cd_reg[s] <= cd_reg[s-1];
        end
    end

    assign det     = det_reg;
    assign cof_out = cd_reg[NST-1];
    assign vld     = v_reg[NST-1];

endmodule

>>> hw/rtl/mi3_div.sv
module mi3_div #(
    parameter int W      = mi3_pkg::DATA_WIDTH_DEF,
    parameter int XW     = 4 * mi3_pkg::DATA_WIDTH_DEF,
    parameter int SIDE_W = mi3_pkg::DATA_WIDTH_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  mi3_pkg::pipe_ctl_t         ctl,
    input  logic [XW-1:0]              x        [mi3_pkg::NELEM],
    input  logic [XW-1:0]              y,
    input  logic [SIDE_W-1:0]          side_in,
    output logic [W:0]                 q        [mi3_pkg::NELEM],
    output logic [mi3_pkg::NELEM-1:0]  ovf,
    output logic [SIDE_W-1:0]          side_out,
    output logic                       vld
);
    import mi3_pkg::*;

    localparam int NS = W + 2;

    logic [XW-1:0]     r_reg    [NS][NELEM];
    logic [W:0]        q_reg    [NS][NELEM];
    logic [NELEM-1:0]  ovf_reg  [NS];
    logic [XW-1:0]     y_reg    [NS];
    logic [SIDE_W-1:0] side_reg [NS];
    logic [NS-1:0]     v_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else if (ctl.adv)
            v_reg <= {v_reg[NS-2:0], ctl.vld};
    end

    // entry stage: flag quotients too large for the magnitude range
    always_ff @(posedge clk)
    begin
        if (ctl.adv)
        begin
            for (int l = 0; l < NELEM; l++)
            begin
                r_reg[0][l]   <= x[l];
                q_reg[0][l]   <= '0;
                ovf_reg[0][l] <= (x[l] >> (W + 1)) >= y;
            end
            y_reg[0]    <= y;
            side_reg[0] <= side_in;
        end
    end

    // one quotient bit per stage, most significant first
    for (genvar s = 1; s < NS; s++)
    begin : g_stage
        localparam int K = NS - 1 - s;
        logic [XW-1:0] r_next [NELEM];
        logic [W:0]    q_next [NELEM];

        always_comb
        begin
            for (int l = 0; l < NELEM; l++)
            begin
                if ((r_reg[s-1][l] >> K) >= y_reg[s-1])
                begin
                    r_next[l] = r_reg[s-1][l] - (y_reg[s-1] << K);
                    q_next[l] = q_reg[s-1][l] | ((W+1)'(1) << K);
                end
                else
                begin
                    r_next[l] = r_reg[s-1][l];
                    q_next[l] = q_reg[s-1][l];
                end
            end
        end

        always_ff @(posedge clk)
        begin
            if (ctl.adv)
            begin
                r_reg[s]    <= r_next;
                q_reg[s]    <= q_next;
                ovf_reg[s]  <= ovf_reg[s-1];
                y_reg[s]    <= y_reg[s-1];
                side_reg[s] <= side_reg[s-1];
            end
        end
    end

    assign q        = q_reg[NS-1];
    assign ovf      = ovf_reg[NS-1];
    assign side_out = side_reg[NS-1];
    assign vld      = v_reg[NS-1];

endmodule

>>> hw/rtl/matrix3_inverse_top.sv
// Channel   Dir  Words                              Handshake
// cfg       in   singular threshold, 31 bits        valid / ready (always ready)
// matrix    in   a00 .. a22, signed Q16.16          valid / ready
// result    out  b00 .. b22, determinant, status    valid / ready
//
// One matrix enters per cycle unless a stalled result holds the pipeline.
// The depth is set by the restoring divider: one quotient bit per stage, nine lanes.
// Reset clears all valid bits and loads the threshold with 1.
// A stalled result freezes the whole pipeline; matrix.ready is high unless a result waits unaccepted.
module matrix3_inverse_top #(
    parameter int DATA_WIDTH = mi3_pkg::DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = mi3_pkg::FRAC_BITS_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    mi3_cfg_if.sink          cfg,
    mi3_mat_if.sink          matrix,
    mi3_res_if.source        result
);
    import mi3_pkg::*;

    localparam int W      = DATA_WIDTH;
    localparam int F      = FRAC_BITS;
    localparam int DW     = 3 * W + 2;
    localparam int TW     = (DW > THR_W + 2 * F) ? DW : THR_W + 2 * F;
    localparam int XW0    = (2 * W + 2 * F + 2 > DW) ? 2 * W + 2 * F + 2 : DW;
    localparam int XW     = XW0 + 1;
    localparam int SIDE_W = NELEM + 1 + W;
    localparam logic [3*W+3:0] HALF = {{(3*W+3){1'b0}}, 1'b1} << (2 * F - 1);
    localparam logic [W:0]   POS_LIM = {2'b00, {(W-1){1'b1}}};
    localparam logic [W:0]   NEG_LIM = {2'b01, {(W-1){1'b0}}};
    localparam logic [W-1:0] MAX_V   = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0] MIN_V   = {1'b1, {(W-1){1'b0}}};

    logic [THR_W-1:0]    thr_reg;
    logic                adv;
    pipe_ctl_t           ctl_in, ctl_det, ctl_f, ctl_div;

    logic signed [W-1:0]   a_in   [NELEM];
    logic signed [2*W:0]   cof_c  [NELEM];
    logic signed [W-1:0]   row0_c [NROW];
    logic                  vld_c;
    logic signed [3*W+2:0] det_d;
    logic signed [2*W:0]   cof_d  [NELEM];
    logic                  vld_d;

    // absolute values, singular test, rounded determinant
    logic signed [3*W+2:0] det_neg;
    logic [DW-1:0]         dabs;
    logic signed [3*W+3:0] rnd_sum;
    logic signed [3*W+3:0] rnd;
    logic [3*W+3-(W-1):0]  rnd_hi;
    logic [W-1:0]          dout;
    logic signed [2*W:0]   cneg   [NELEM];
    logic [DW-1:0]         dabs_reg;
    logic                  sing_reg;
    logic [W-1:0]          dout_reg;
    logic [2*W:0]          ac_reg [NELEM];
    logic [NELEM-1:0]      neg_reg;
    logic                  vf_reg;

    // dividend and divisor
    logic [XW-1:0]         x_reg  [NELEM];
    logic [XW-1:0]         y_reg;
    logic [SIDE_W-1:0]     side_g_reg;
    logic                  vg_reg;

    logic [W:0]            q_o    [NELEM];
    logic [NELEM-1:0]      ovf_o;
    logic [SIDE_W-1:0]     side_o;
    logic                  vld_o;
    logic [NELEM-1:0]      neg_o;
    logic                  sing_o;
    logic [W:0]            qn     [NELEM];
    logic [W-1:0]          b_next [NELEM];

    logic [W-1:0]          b_reg  [NELEM];
    logic [W-1:0]          det_reg;
    status_t               st_reg;
    logic                  ov_reg;

    assign adv = !ov_reg || result.ready;

    assign matrix.ready = adv;
    assign cfg.ready    = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            thr_reg <= THR_RESET;
        else if (cfg.valid)
            thr_reg <= cfg.data;
    end

    assign a_in[0] = matrix.a00;
    assign a_in[1] = matrix.a01;
    assign a_in[2] = matrix.a02;
    assign a_in[3] = matrix.a10;
    assign a_in[4] = matrix.a11;
    assign a_in[5] = matrix.a12;
    assign a_in[6] = matrix.a20;
    assign a_in[7] = matrix.a21;
    assign a_in[8] = matrix.a22;

    assign ctl_in  = '{adv: adv, vld: matrix.valid};
    assign ctl_det = '{adv: adv, vld: vld_c};
    assign ctl_f   = '{adv: adv, vld: vld_d};
    assign ctl_div = '{adv: adv, vld: vg_reg};

    mi3_cof #(.W(W)) u_cof (
        .clk  (clk),
        .rst_n(rst_n),
        .ctl  (ctl_in),
        .a    (a_in),
        .cof  (cof_c),
        .row0 (row0_c),
        .vld  (vld_c)
    );

    mi3_det #(.W(W)) u_det (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl    (ctl_det),
        .cof    (cof_c),
        .row0   (row0_c),
        .det    (det_d),
        .cof_out(cof_d),
        .vld    (vld_d)
    );

    always_comb
    begin
        det_neg = -det_d;
        dabs    = det_d[3*W+2] ? det_neg[DW-1:0] : det_d[DW-1:0];
        rnd_sum = $signed({det_d[3*W+2], det_d}) + $signed(HALF);
        rnd     = rnd_sum >>> (2 * F);
        rnd_hi  = rnd[3*W+3:W-1];
        if ((&rnd_hi) || !(|rnd_hi))
            dout = rnd[W-1:0];
        else
            dout = rnd[3*W+3] ? MIN_V : MAX_V;
        for (int k = 0; k < NELEM; k++)
            cneg[k] = -cof_d[k];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vf_reg <= 1'b0;
            vg_reg <= 1'b0;
        end
        else if (adv)
        begin
            vf_reg <= ctl_f.vld;
            vg_reg <= vf_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dabs_reg <= dabs;
            sing_reg <= TW'(dabs) <= (TW'(thr_reg) << (2 * F));
            dout_reg <= dout;
            for (int k = 0; k < NELEM; k++)
            begin
                ac_reg[k]  <= cof_d[k][2*W] ? cneg[k] : cof_d[k];
                neg_reg[k] <= cof_d[k][2*W] ^ det_d[3*W+2];
            end

            // round half away: floor((2|c|*2^2F + |d|) / 2|d|)
            for (int k = 0; k < NELEM; k++)
                x_reg[k] <= (XW'(ac_reg[k]) << (2 * F + 1)) + XW'(dabs_reg);
            y_reg      <= XW'(dabs_reg) << 1;
            side_g_reg <= {neg_reg, sing_reg, dout_reg};
        end
    end

    mi3_div #(.W(W), .XW(XW), .SIDE_W(SIDE_W)) u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (ctl_div),
        .x       (x_reg),
        .y       (y_reg),
        .side_in (side_g_reg),
        .q       (q_o),
        .ovf     (ovf_o),
        .side_out(side_o),
        .vld     (vld_o)
    );

    assign neg_o  = side_o[SIDE_W-1:W+1];
    assign sing_o = side_o[W];

    always_comb
    begin
        for (int k = 0; k < NELEM; k++)
        begin
            qn[k] = ~q_o[k] + 1'b1;
            if (sing_o)
                b_next[k] = '0;
            else if (neg_o[k])
                b_next[k] = (ovf_o[k] || q_o[k] > NEG_LIM) ? MIN_V : qn[k][W-1:0];
            else
                b_next[k] = (ovf_o[k] || q_o[k] > POS_LIM) ? MAX_V : q_o[k][W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ov_reg <= 1'b0;
        else if (adv)
            ov_reg <= vld_o;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            b_reg   <= b_next;
            det_reg <= side_o[W-1:0];
            st_reg  <= sing_o ? STATUS_SINGULAR : STATUS_OK;
        end
    end

    assign result.valid       = ov_reg;
    assign result.b00         = b_reg[0];
    assign result.b01         = b_reg[1];
    assign result.b02         = b_reg[2];
    assign result.b10         = b_reg[3];
    assign result.b11         = b_reg[4];
    assign result.b12         = b_reg[5];
    assign result.b20         = b_reg[6];
    assign result.b21         = b_reg[7];
    assign result.b22         = b_reg[8];
    assign result.determinant = det_reg;
    assign result.status      = st_reg;

endmodule

>>> hw/rtl/mi3_chk.sv
module mi3_chk #(
    parameter int W = mi3_pkg::DATA_WIDTH_DEF
) (
    input logic           clk,
    input logic           rst_n,
    input logic           in_ready,
    input logic           out_valid,
    input logic           out_ready,
    input logic           status,
    input logic [9*W-1:0] elems,
    input logic [W-1:0]   determinant
);

    a_hold_valid : assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result word dropped while stalled");

    a_hold_data : assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(elems) && $stable(determinant))
        else $error("result word changed while stalled");

    a_singular_zero : assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status |-> elems == '0)
        else $error("singular result carries nonzero elements");

    a_stall_input : assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |-> !in_ready)
        else $error("matrix taken while the pipeline is stalled");

endmodule

bind matrix3_inverse_top mi3_chk #(.W(DATA_WIDTH)) u_chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ready   (matrix.ready),
    .out_valid  (result.valid),
    .out_ready  (result.ready),
    .status     (result.status),
    .elems      ({result.b00, result.b01, result.b02, result.b10, result.b11,
                  result.b12, result.b20, result.b21, result.b22}),
    .determinant(result.determinant)
);

>>> bench/testbench.sv
module testbench;
    import mi3_pkg::*;

    localparam int DW         = 32;
    localparam int LATENCY    = DW + 10;
    localparam int CYCLE_CAP  = 400000;
    localparam int N_RANDOM   = 160;
    localparam int N_PHASES   = 6;

    localparam logic signed [DW-1:0] ONE  = 32'sh0001_0000;
    localparam logic signed [DW-1:0] VMAX = 32'sh7FFF_FFFF;
    localparam logic signed [DW-1:0] VMIN = 32'sh8000_0000;
    localparam logic [THR_W-1:0]     THR_MAX = {THR_W{1'b1}};

    typedef logic signed [191:0] wide_t;

    typedef struct {
        logic signed [DW-1:0] a [NELEM];
    } matrix_t;

    typedef struct {
        logic signed [DW-1:0] b [NELEM];
        logic signed [DW-1:0] det;
        status_t              st;
    } inverse_t;

    typedef struct {
        matrix_t  m;
        bit       typed;
        inverse_t r;
    } stim_row_t;

    logic clk;
    logic rst_n;

    mi3_cfg_if cfg_ch ();
    mi3_mat_if mat_ch ();
    mi3_res_if res_ch ();

    matrix3_inverse_top u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg_ch),
        .matrix (mat_ch),
        .result (res_ch)
    );

    inverse_t         inverse_q [$];
    logic [THR_W-1:0] thr_shadow;
    bit               cur_typed;
    inverse_t         cur_inverse;
    int unsigned      mismatches;
    int unsigned      n_words_in;
    int unsigned      n_words_out;
    int unsigned      n_singular;
    int unsigned      n_cfg;
    int unsigned      cycles;
    bit               stim_done;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // ---------------------------------------------------------------- predictor
    function automatic logic signed [DW-1:0] clamp_q16(input wide_t v);
        if (v > wide_t'(VMAX))
            return VMAX;
        if (v < wide_t'(VMIN))
            return VMIN;
        return v[DW-1:0];
    endfunction

    function automatic inverse_t predict_inverse(input matrix_t m, input logic [THR_W-1:0] thr);
        wide_t    e [NELEM];
        wide_t    cof [NELEM];
        wide_t    det;
        wide_t    adet;
        wide_t    num;
        wide_t    q;
        bit       sing;
        inverse_t r;
        for (int k = 0; k < NELEM; k++)
            e[k] = wide_t'(m.a[k]);
        for (int k = 0; k < NELEM; k++)
            cof[k] = e[COF_IDX[k][0]] * e[COF_IDX[k][1]] - e[COF_IDX[k][2]] * e[COF_IDX[k][3]];
        det = e[0] * cof[0] + e[1] * cof[3] + e[2] * cof[6];
        // round half up from Q48 down to Q16
        r.det = clamp_q16((det + (wide_t'(1) <<< 31)) >>> 32);
        adet = (det < 0) ? -det : det;
        sing = adet <= (wide_t'(thr) <<< 32);
        r.st = sing ? STATUS_SINGULAR : STATUS_OK;
        for (int k = 0; k < NELEM; k++)
        begin
            if (sing)
            begin
                r.b[k] = '0;
            end
            else
            begin
                num = ((cof[k] < 0) ? -cof[k] : cof[k]) <<< 32;
                q = (2 * num + adet) / (2 * adet);
                if ((cof[k] < 0) != (det < 0))
                    q = -q;
                r.b[k] = clamp_q16(q);
            end
        end
        return r;
    endfunction

    // ---------------------------------------------------------------- stimulus helpers
    function automatic matrix_t diag_matrix(input logic signed [DW-1:0] d0,
                                            input logic signed [DW-1:0] d1,
                                            input logic signed [DW-1:0] d2);
        matrix_t m;
        foreach (m.a[k])
            m.a[k] = '0;
        m.a[0] = d0;
        m.a[4] = d1;
        m.a[8] = d2;
        return m;
    endfunction

    function automatic matrix_t fill_matrix(input logic signed [DW-1:0] v);
        matrix_t m;
        foreach (m.a[k])
            m.a[k] = v;
        return m;
    endfunction

    function automatic inverse_t typed_inverse(input logic signed [DW-1:0] d,
                                               input logic signed [DW-1:0] det,
                                               input status_t st);
        inverse_t r;
        foreach (r.b[k])
            r.b[k] = ((k % 4) == 0) ? d : '0;
        r.det = det;
        r.st  = st;
        return r;
    endfunction

    function automatic logic signed [DW-1:0] rand_elem(input int unsigned kind);
        case (kind)
            0: return $urandom();
            1: return $signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000;
            2: return $signed($urandom_range(0, 32'h0100_0000)) - 32'sh0080_0000;
            default: return $signed($urandom_range(0, 32'h0000_0400)) - 32'sh0000_0200;
        endcase
    endfunction

    function automatic matrix_t rand_matrix();
        matrix_t     m;
        int unsigned kind;
        int unsigned shape;
        kind  = $urandom_range(0, 3);
        shape = $urandom_range(0, 9);
        foreach (m.a[k])
            m.a[k] = rand_elem(kind);
        if (shape < 2)
        begin
            // nearly dependent rows: det lands near the threshold
            for (int c = 0; c < NROW; c++)
                m.a[6 + c] = m.a[c] + m.a[3 + c] + ($signed($urandom_range(0, 6)) - 3);
        end
        else if (shape == 2)
        begin
            m.a[$urandom_range(0, 8)] = $urandom_range(0, 1) ? VMAX : VMIN;
        end
        return m;
    endfunction

    function automatic void load_directed(ref stim_row_t rows [$]);
        stim_row_t row;
        matrix_t   m;
        row.typed = 1'b1;
        row.m = diag_matrix(ONE, ONE, ONE);
        row.r = typed_inverse(ONE, ONE, STATUS_OK);
        rows.push_back(row);
        row.m = fill_matrix('0);
        row.r = typed_inverse('0, '0, STATUS_SINGULAR);
        rows.push_back(row);
        row.m = diag_matrix(2 * ONE, 2 * ONE, 2 * ONE);
        row.r = typed_inverse(32'sh0000_8000, 32'sh0008_0000, STATUS_OK);
        rows.push_back(row);
        // rank one: determinant exactly zero
        row.m = fill_matrix(VMAX);
        row.r = typed_inverse('0, '0, STATUS_SINGULAR);
        rows.push_back(row);
        row.m = fill_matrix(VMIN);
        rows.push_back(row);

        row.typed = 1'b0;
        row.m = diag_matrix(VMAX, VMAX, VMAX);
        rows.push_back(row);
        row.m = diag_matrix(VMIN, VMIN, VMIN);
        rows.push_back(row);
        row.m = diag_matrix(VMIN, VMAX, -ONE);
        rows.push_back(row);
        row.m = diag_matrix(1, 1, 1);
        rows.push_back(row);
        // determinant right at the default threshold, then just above it
        row.m = diag_matrix(ONE, ONE, 1);
        rows.push_back(row);
        row.m = diag_matrix(ONE, ONE, 2);
        rows.push_back(row);
        row.m = diag_matrix(-ONE, 2 * ONE, -4 * ONE);
        rows.push_back(row);
        row.m = diag_matrix(3 * ONE, ONE, 7 * ONE);
        rows.push_back(row);
        m = fill_matrix('0);
        m.a[1] = ONE;
        m.a[5] = ONE;
        m.a[6] = ONE;
        row.m = m;
        rows.push_back(row);
        foreach (m.a[k])
            m.a[k] = (k % 2) ? 32'shAAAA_AAAA : 32'sh5555_5555;
        m.a[4] = 32'sh0000_3333;
        row.m = m;
        rows.push_back(row);
        foreach (m.a[k])
            m.a[k] = (k % 3 == 0) ? -32'sh0001_8000 : ((k > 4) ? 32'sh0000_0001 : 32'sh0002_4000);
        row.m = m;
        rows.push_back(row);
        foreach (m.a[k])
            m.a[k] = ~(32'sh0000_0001 << (3 * k));
        row.m = m;
        rows.push_back(row);
    endfunction

    // ---------------------------------------------------------------- drivers
    bit send_calm;
    bit recv_calm;

    task automatic wait_matrix_ready();
        forever
        begin
            @(negedge clk);
            if (mat_ch.ready)
                break;
        end
        @(posedge clk);
    endtask

    task automatic send_matrix(input matrix_t m, input bit typed, input inverse_t r);
        int unsigned gap;
        gap = send_calm ? 0 : $urandom_range(0, 10);
        if (gap > 0)
        begin
            mat_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        mat_ch.a00  <= m.a[0];
        mat_ch.a01  <= m.a[1];
        mat_ch.a02  <= m.a[2];
        mat_ch.a10  <= m.a[3];
        mat_ch.a11  <= m.a[4];
        mat_ch.a12  <= m.a[5];
        mat_ch.a20  <= m.a[6];
        mat_ch.a21  <= m.a[7];
        mat_ch.a22  <= m.a[8];
        cur_typed   <= typed;
        cur_inverse <= r;
        mat_ch.valid <= 1'b1;
        wait_matrix_ready();
    endtask

    task automatic write_threshold(input logic [THR_W-1:0] v);
        mat_ch.valid <= 1'b0;
        @(posedge clk);
        while (inverse_q.size() != 0)
            @(posedge clk);
        repeat (LATENCY) @(posedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= v;
        forever
        begin
            @(negedge clk);
            if (cfg_ch.ready)
                break;
        end
        @(posedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    initial
    begin
        stim_row_t        rows [$];
        inverse_t         dummy;
        logic [THR_W-1:0] thr_plan [N_PHASES];

        rst_n        <= 1'b0;
        cfg_ch.valid <= 1'b0;
        cfg_ch.data  <= '0;
        mat_ch.valid <= 1'b0;
        {mat_ch.a00, mat_ch.a01, mat_ch.a02} <= '0;
        {mat_ch.a10, mat_ch.a11, mat_ch.a12} <= '0;
        {mat_ch.a20, mat_ch.a21, mat_ch.a22} <= '0;
        cur_typed    <= 1'b0;
        stim_done    = 1'b0;
        send_calm    = 1'b0;
        dummy        = typed_inverse('0, '0, STATUS_OK);
        cur_inverse  <= dummy;
        load_directed(rows);
        thr_plan = '{THR_RESET, '0, THR_MAX, THR_W'($urandom()),
                     THR_W'($urandom_range(0, 32'h0002_0000)), THR_RESET};

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (rows[i])
            send_matrix(rows[i].m, rows[i].typed, rows[i].r);

        for (int p = 0; p < N_PHASES; p++)
        begin
            if (p > 0)
                write_threshold(thr_plan[p]);
            for (int i = 0; i < N_RANDOM; i++)
            begin
                if (i % 40 == 0)
                    send_calm = ($urandom_range(0, 3) == 0);
                send_matrix(rand_matrix(), 1'b0, dummy);
            end
        end
        mat_ch.valid <= 1'b0;
        stim_done = 1'b1;
    end

    initial
    begin
        int unsigned stall;
        int unsigned served;
        res_ch.ready <= 1'b1;
        recv_calm = 1'b0;
        served = 0;
        forever
        begin
            if (served % 50 == 0)
                recv_calm = ($urandom_range(0, 3) == 0);
            stall = recv_calm ? 0 : $urandom_range(0, 10);
            if (stall > 0)
            begin
                res_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
                res_ch.ready <= 1'b1;
            end
            forever
            begin
                @(negedge clk);
                if (res_ch.valid)
                    break;
            end
            @(posedge clk);
            served++;
        end
    end

    // ---------------------------------------------------------------- monitors
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_shadow <= THR_RESET;
            n_cfg      <= 0;
        end
        else if (cfg_ch.valid && cfg_ch.ready)
        begin
            thr_shadow <= cfg_ch.data;
            n_cfg      <= n_cfg + 1;
        end
    end

    always @(posedge clk)
    begin
        matrix_t m;
        if (rst_n && mat_ch.valid && mat_ch.ready)
        begin
            m.a = '{mat_ch.a00, mat_ch.a01, mat_ch.a02, mat_ch.a10, mat_ch.a11,
                    mat_ch.a12, mat_ch.a20, mat_ch.a21, mat_ch.a22};
            inverse_q.push_back(cur_typed ? cur_inverse : predict_inverse(m, thr_shadow));
            n_words_in <= n_words_in + 1;
        end
    end

    always @(posedge clk)
    begin
        inverse_t got;
        inverse_t want;
        bit       bad;
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            got.b = '{res_ch.b00, res_ch.b01, res_ch.b02, res_ch.b10, res_ch.b11,
                      res_ch.b12, res_ch.b20, res_ch.b21, res_ch.b22};
            got.det = res_ch.determinant;
            got.st  = res_ch.status;
            n_words_out <= n_words_out + 1;
            if (got.st == STATUS_SINGULAR)
                n_singular <= n_singular + 1;
            if (inverse_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: result word with nothing expected, det %h", got.det);
            end
            else
            begin
                want = inverse_q.pop_front();
                bad = (got.det !== want.det) || (got.st !== want.st);
                foreach (got.b[k])
                    if (got.b[k] !== want.b[k])
                        bad = 1'b1;
                if (bad)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                    begin
                        $display("ERROR: result word %0d mismatch", n_words_out);
                        $display("  expected b %p det %h status %s",
                                 want.b, want.det, want.st.name());
                        $display("  actual   b %p det %h status %s",
                                 got.b, got.det, got.st.name());
                    end
                end
            end
        end
    end

    initial
    begin
        mismatches  = 0;
        n_words_in  = 0;
        n_words_out = 0;
        n_singular  = 0;
        cycles      = 0;
    end

    // ---------------------------------------------------------------- end of run
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_CAP)
        begin
            $display("timeout after %0d cycles, %0d words still expected",
                     cycles, inverse_q.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial
    begin
        wait (stim_done);
        while (inverse_q.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 20) @(posedge clk);
        if (inverse_q.size() != 0)
        begin
            mismatches++;
            $display("ERROR: %0d expected words never arrived", inverse_q.size());
        end
        $display("matrices in %0d, results out %0d (%0d singular), threshold writes %0d",
                 n_words_in, n_words_out, n_singular, n_cfg);
        $display("random stalls on both channels, threshold from 0 to max, mismatches %0d",
                 mismatches);
        if (mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

>>> files.f
hw/rtl/mi3_pkg.sv
hw/rtl/mi3_cfg_if.sv
hw/rtl/mi3_mat_if.sv
hw/rtl/mi3_res_if.sv
hw/rtl/mi3_cof.sv
hw/rtl/mi3_det.sv
hw/rtl/mi3_div.sv
hw/rtl/matrix3_inverse_top.sv
hw/rtl/mi3_chk.sv
bench/testbench.sv
